// ===== rtl/core/morse_code_led_keyer_defines.svh =====
`ifndef MORSE_CODE_LED_KEYER_DEFINES_SVH
`define MORSE_CODE_LED_KEYER_DEFINES_SVH

`ifndef ASSERT_OFF

`define KEY_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keyer assertion failed");

`define KEY_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keyer assertion failed");

`else

`define KEY_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define KEY_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/mclk_pkg.sv =====
package mclk_pkg;

    localparam int TICKER_DEPTH   = 32;
    localparam int TELEGRAM_DEPTH = 32;
    localparam int TK_AW          = $clog2(TICKER_DEPTH);
    localparam int TG_AW          = $clog2(TELEGRAM_DEPTH);
    localparam int TG_CW          = $clog2(TELEGRAM_DEPTH + 1);

    localparam int UNIT_W   = 16;
    localparam int LEN_W    = 6;
    localparam int TICK_W   = 18;
    localparam int CHAR_W   = 7;
    localparam int SLOT_W   = 5;
    localparam int POS_W    = 4;
    localparam int CFG_DW   = 16;

    localparam logic [31:0]        SPACE_WORD       = 32'hFFFF_FFF0;
    localparam logic [UNIT_W-1:0]  UNIT_TICKS_RESET = 16'd100;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_PUSH  = 2'd2,
        ACT_LOAD  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        SYM_GAP  = 2'd0,
        SYM_DOT  = 2'd1,
        SYM_DASH = 2'd2,
        SYM_END  = 2'd3
    } t_symbol;

    typedef enum logic {
        CFG_UNIT_TICKS    = 1'b0,
        CFG_TICKER_LENGTH = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_action            action;
        logic [CHAR_W-1:0]  char_code;
        logic [SLOT_W-1:0]  slot;
    } t_in_item;

    typedef struct packed {
        logic led_on;
        logic telegram_active;
        logic keyer_running;
        logic fifo_full;
    } t_out_item;

    localparam logic [31:0] ROM_CODES [128] = '{
        32'hFFFFFFF0, 32'hFFF12111, 32'hD1111111, 32'hFFF21212,
        32'hFFF12121, 32'hF2121112, 32'hD1211212, 32'hFF212111,
        32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0,
        32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0,
        32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0,
        32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0,
        32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0,
        32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0,
        32'hFFFFFFF0, 32'hFF221212, 32'hFF121121, 32'hFFFFFFF0,
        32'hF2112111, 32'hFFFFFFF0, 32'hFFF11121, 32'hFF122221,
        32'hFFF12212, 32'hFF212212, 32'hFFFFFFF0, 32'hFFF12121,
        32'hFF221122, 32'hFF211112, 32'hFF212121, 32'hFFF12112,
        32'hFFF22222, 32'hFFF22221, 32'hFFF22211, 32'hFFF22111,
        32'hFFF21111, 32'hFFF11111, 32'hFFF11112, 32'hFFF11122,
        32'hFFF11222, 32'hFFF12222, 32'hFF111222, 32'hFF121212,
        32'hFFFFFFF0, 32'hFFF21112, 32'hFFFFFFF0, 32'hFF112211,
        32'hFF121221, 32'hFFFFFF21, 32'hFFFF1112, 32'hFFFF1212,
        32'hFFFFF112, 32'hFFFFFFF1, 32'hFFFF1211, 32'hFFFFF122,
        32'hFFFF1111, 32'hFFFFFF11, 32'hFFFF2221, 32'hFFFFF212,
        32'hFFFF1121, 32'hFFFFFF22, 32'hFFFFFF12, 32'hFFFFF222,
        32'hFFFF1221, 32'hFFFF2122, 32'hFFFFF121, 32'hFFFFF111,
        32'hFFFFFFF2, 32'hFFFFF211, 32'hFFFF2111, 32'hFFFFF221,
        32'hFFFF2112, 32'hFFFF2212, 32'hFFFF1122, 32'hFFFFFFF0,
        32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFF212211,
        32'hFFFFFFF0, 32'hFFFFFF21, 32'hFFFF1112, 32'hFFFF1212,
        32'hFFFFF112, 32'hFFFFFFF1, 32'hFFFF1211, 32'hFFFFF122,
        32'hFFFF1111, 32'hFFFFFF11, 32'hFFFF2221, 32'hFFFFF212,
        32'hFFFF1121, 32'hFFFFFF22, 32'hFFFFFF12, 32'hFFFFF222,
        32'hFFFF1221, 32'hFFFF2122, 32'hFFFFF121, 32'hFFFFF111,
        32'hFFFFFFF2, 32'hFFFFF211, 32'hFFFF2111, 32'hFFFFF221,
        32'hFFFF2112, 32'hFFFF2212, 32'hFFFF1122, 32'hFFFFFFF0,
        32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0, 32'hFFFFFFF0
    };

endpackage

// ===== rtl/core/morse_code_led_keyer.sv =====
// Morse keyer for one LED. Every request updates the state as it is accepted, and its result
// appears in the output register on the next cycle, so with the result side not stalling
// one request is accepted in every cycle. The figure is set by the single state update
// path: telegram FIFO or ticker store read, character ROM lookup and letter register.
// The result register frees itself when its result is taken, so a new request is accepted
// in the same cycle in which the previous result leaves. Telegram characters are played
// before the repeating ticker message; a ticker slot must be written before it is played.
`include "morse_code_led_keyer_defines.svh"

module morse_code_led_keyer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  mclk_pkg::t_in_item       i_in,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output mclk_pkg::t_out_item      o_out,
    input  logic                     i_out_stall,
    input  logic                     i_cfg_we,
    input  mclk_pkg::t_cfg_index     i_cfg_index,
    input  logic [mclk_pkg::CFG_DW-1:0] i_cfg_data
);
    import mclk_pkg::*;

    logic [UNIT_W-1:0]  r_unit_ticks;
    logic [LEN_W-1:0]   r_ticker_length;

    logic [31:0]        r_letter_code, n_letter_code;
    logic [POS_W-1:0]   r_symbol_pos, n_symbol_pos;
    logic [TICK_W-1:0]  r_tick_count, n_tick_count;
    logic [TK_AW-1:0]   r_ticker_index, n_ticker_index;
    logic [TG_CW-1:0]   r_fifo_count, n_fifo_count;
    logic [TG_AW-1:0]   r_fifo_read_ptr, n_fifo_read_ptr;
    logic               r_telegram_flag, n_telegram_flag;
    logic               r_led_level, n_led_level;

    logic [CHAR_W-1:0]  r_ticker_store [TICKER_DEPTH];
    logic [CHAR_W-1:0]  r_telegram_fifo [TELEGRAM_DEPTH];

    logic               r_out_valid;
    t_out_item          r_out, n_out;

    logic               in_accept;
    logic               running;
    logic               fifo_full;
    logic               ticker_we;
    logic               push_we;
    logic               load;
    logic               from_fifo;
    logic [CHAR_W-1:0]  load_char;
    logic [TK_AW:0]     ticker_next;
    logic [TG_AW-1:0]   fifo_write_ptr;
    logic [TICK_W-1:0]  unit_x1, unit_x2, unit_x3;
    t_symbol            sym;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign running        = r_telegram_flag || (r_ticker_length != '0);
    assign fifo_full      = (r_fifo_count >= TG_CW'(TELEGRAM_DEPTH));
    assign fifo_write_ptr = r_fifo_read_ptr + r_fifo_count[TG_AW-1:0];
    assign ticker_next    = {1'b0, r_ticker_index} + (TK_AW+1)'(1);
    assign unit_x1        = TICK_W'(r_unit_ticks);
    assign unit_x2        = {unit_x1[TICK_W-2:0], 1'b0};
    assign unit_x3        = unit_x1 + unit_x2;
    assign sym            = t_symbol'(r_letter_code[{r_symbol_pos, 1'b0} +: 2]);
    assign from_fifo      = r_telegram_flag && (r_fifo_count != '0);

    always_comb begin
        n_letter_code   = r_letter_code;
        n_symbol_pos    = r_symbol_pos;
        n_tick_count    = r_tick_count;
        n_ticker_index  = r_ticker_index;
        n_fifo_count    = r_fifo_count;
        n_fifo_read_ptr = r_fifo_read_ptr;
        n_telegram_flag = r_telegram_flag;
        n_led_level     = r_led_level;
        ticker_we       = 1'b0;
        push_we         = 1'b0;
        load            = 1'b0;
        load_char       = r_telegram_fifo[r_fifo_read_ptr];

        case (i_in.action)
            ACT_TICK: begin
                if (running) begin
                    if (r_tick_count != '0) begin
                        n_tick_count = r_tick_count - TICK_W'(1);
                    end else begin
                        case (sym)
                            SYM_GAP: begin
                                n_led_level  = 1'b0;
                                n_tick_count = unit_x1;
                                n_symbol_pos = r_symbol_pos + POS_W'(1);
                            end
                            SYM_DOT: begin
                                n_led_level  = 1'b1;
                                n_tick_count = unit_x1;
                                n_symbol_pos = r_symbol_pos + POS_W'(1);
                            end
                            SYM_DASH: begin
                                n_led_level  = 1'b1;
                                n_tick_count = unit_x3;
                                n_symbol_pos = r_symbol_pos + POS_W'(1);
                            end
                            default: begin
                                n_led_level  = 1'b0;
                                n_tick_count = unit_x2;
                                load         = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ACT_WRITE: begin
                ticker_we = 1'b1;
            end
            ACT_PUSH: begin
                n_telegram_flag = 1'b1;
                if (!fifo_full) begin
                    push_we      = 1'b1;
                    n_fifo_count = r_fifo_count + TG_CW'(1);
                end
            end
            default: begin
                load = 1'b1;
            end
        endcase

        if (load) begin
            n_symbol_pos = '0;
            if (r_telegram_flag && (r_fifo_count == '0)) begin
                n_telegram_flag = 1'b0;
            end
            if (from_fifo) begin
                n_fifo_read_ptr = r_fifo_read_ptr + TG_AW'(1);
                n_fifo_count    = r_fifo_count - TG_CW'(1);
                n_letter_code   = ROM_CODES[load_char];
            end else if (r_ticker_length == '0) begin
                n_ticker_index = '0;
                n_letter_code  = SPACE_WORD;
            end else begin
                load_char     = r_ticker_store[r_ticker_index];
                n_letter_code = ROM_CODES[load_char];
                if ((ticker_next >= (TK_AW+1)'(r_ticker_length))
                        || (ticker_next >= (TK_AW+1)'(TICKER_DEPTH))) begin
                    n_ticker_index = '0;
                end else begin
                    n_ticker_index = ticker_next[TK_AW-1:0];
                end
            end
        end
    end

    always_comb begin
        n_out.led_on          = n_led_level;
        n_out.telegram_active = n_telegram_flag;
        n_out.keyer_running   = n_telegram_flag || (r_ticker_length != '0);
        n_out.fifo_full       = (n_fifo_count >= TG_CW'(TELEGRAM_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks    <= UNIT_TICKS_RESET;
            r_ticker_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_UNIT_TICKS:    r_unit_ticks    <= i_cfg_data[UNIT_W-1:0];
                CFG_TICKER_LENGTH: r_ticker_length <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_letter_code   <= SPACE_WORD;
            r_symbol_pos    <= '0;
            r_tick_count    <= '0;
            r_ticker_index  <= '0;
            r_fifo_count    <= '0;
            r_fifo_read_ptr <= '0;
            r_telegram_flag <= 1'b0;
            r_led_level     <= 1'b0;
        end else if (in_accept) begin
            r_letter_code   <= n_letter_code;
            r_symbol_pos    <= n_symbol_pos;
            r_tick_count    <= n_tick_count;
            r_ticker_index  <= n_ticker_index;
            r_fifo_count    <= n_fifo_count;
            r_fifo_read_ptr <= n_fifo_read_ptr;
            r_telegram_flag <= n_telegram_flag;
            r_led_level     <= n_led_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && ticker_we) begin
            r_ticker_store[i_in.slot[TK_AW-1:0]] <= i_in.char_code;
        end
        if (in_accept && push_we) begin
            r_telegram_fifo[fifo_write_ptr] <= i_in.char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    `KEY_ASSERT_IMP(a_fifo_bound, i_clk, i_rst_n, 1'b1, r_fifo_count <= TG_CW'(TELEGRAM_DEPTH))
    `KEY_ASSERT_IMP(a_fifo_flag, i_clk, i_rst_n, r_fifo_count != '0, r_telegram_flag)
    `KEY_ASSERT_NXT(a_result_held, i_clk, i_rst_n, in_accept, r_out_valid)
    `KEY_ASSERT_NXT(a_idle_tick, i_clk, i_rst_n, in_accept && (i_in.action == ACT_TICK) && !running, $stable(r_tick_count) && $stable(r_led_level))

endmodule

// ===== test/morse_keyer_status_check.sv =====
module morse_keyer_status_check (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  mclk_pkg::t_in_item           i_in,
    input  logic                         i_in_stall,
    input  logic                         i_out_valid,
    input  mclk_pkg::t_out_item          i_out,
    input  logic                         i_out_stall,
    input  logic                         i_cfg_we,
    input  mclk_pkg::t_cfg_index         i_cfg_index,
    input  logic [mclk_pkg::CFG_DW-1:0]  i_cfg_data,
    output int                           o_mismatches,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mclk_pkg::*;

    logic [UNIT_W-1:0]  unit_ticks;
    logic [LEN_W-1:0]   ticker_len;
    logic [31:0]        letter_word;
    logic [POS_W-1:0]   sym_pos;
    logic [TICK_W-1:0]  tick_cnt;
    logic [CHAR_W-1:0]  ticker_mem [TICKER_DEPTH];
    logic [TK_AW-1:0]   ticker_idx;
    logic [CHAR_W-1:0]  telegram_mem [TELEGRAM_DEPTH];
    logic [TG_CW-1:0]   telegram_count;
    logic [TG_AW-1:0]   telegram_rd_ptr;
    logic               telegram_on;
    logic               led;

    t_out_item          status_q [$];

    function automatic logic [31:0] morse_word(input logic [CHAR_W-1:0] ch);
        case (ch)
            7'd1:         return 32'hFFF12111;
            7'd2:         return 32'hD1111111;
            7'd3:         return 32'hFFF21212;
            7'd4:         return 32'hFFF12121;
            7'd5:         return 32'hF2121112;
            7'd6:         return 32'hD1211212;
            7'd7:         return 32'hFF212111;
            7'd33:        return 32'hFF221212;
            7'd34:        return 32'hFF121121;
            7'd36:        return 32'hF2112111;
            7'd38:        return 32'hFFF11121;
            7'd39:        return 32'hFF122221;
            7'd40:        return 32'hFFF12212;
            7'd41:        return 32'hFF212212;
            7'd43:        return 32'hFFF12121;
            7'd44:        return 32'hFF221122;
            7'd45:        return 32'hFF211112;
            7'd46:        return 32'hFF212121;
            7'd47:        return 32'hFFF12112;
            7'd48:        return 32'hFFF22222;
            7'd49:        return 32'hFFF22221;
            7'd50:        return 32'hFFF22211;
            7'd51:        return 32'hFFF22111;
            7'd52:        return 32'hFFF21111;
            7'd53:        return 32'hFFF11111;
            7'd54:        return 32'hFFF11112;
            7'd55:        return 32'hFFF11122;
            7'd56:        return 32'hFFF11222;
            7'd57:        return 32'hFFF12222;
            7'd58:        return 32'hFF111222;
            7'd59:        return 32'hFF121212;
            7'd61:        return 32'hFFF21112;
            7'd63:        return 32'hFF112211;
            7'd64:        return 32'hFF121221;
            7'd65, 7'd97:  return 32'hFFFFFF21;
            7'd66, 7'd98:  return 32'hFFFF1112;
            7'd67, 7'd99:  return 32'hFFFF1212;
            7'd68, 7'd100: return 32'hFFFFF112;
            7'd69, 7'd101: return 32'hFFFFFFF1;
            7'd70, 7'd102: return 32'hFFFF1211;
            7'd71, 7'd103: return 32'hFFFFF122;
            7'd72, 7'd104: return 32'hFFFF1111;
            7'd73, 7'd105: return 32'hFFFFFF11;
            7'd74, 7'd106: return 32'hFFFF2221;
            7'd75, 7'd107: return 32'hFFFFF212;
            7'd76, 7'd108: return 32'hFFFF1121;
            7'd77, 7'd109: return 32'hFFFFFF22;
            7'd78, 7'd110: return 32'hFFFFFF12;
            7'd79, 7'd111: return 32'hFFFFF222;
            7'd80, 7'd112: return 32'hFFFF1221;
            7'd81, 7'd113: return 32'hFFFF2122;
            7'd82, 7'd114: return 32'hFFFFF121;
            7'd83, 7'd115: return 32'hFFFFF111;
            7'd84, 7'd116: return 32'hFFFFFFF2;
            7'd85, 7'd117: return 32'hFFFFF211;
            7'd86, 7'd118: return 32'hFFFF2111;
            7'd87, 7'd119: return 32'hFFFFF221;
            7'd88, 7'd120: return 32'hFFFF2112;
            7'd89, 7'd121: return 32'hFFFF2212;
            7'd90, 7'd122: return 32'hFFFF1122;
            7'd95:        return 32'hFF212211;
            default:      return SPACE_WORD;
        endcase
    endfunction

    // Telegram characters win over the ticker; an empty FIFO ends the telegram.
    function automatic void fetch_letter();
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  idx_next;
        logic              from_telegram;
        ch = '0;
        from_telegram = 1'b0;
        if (telegram_on) begin
            if (telegram_count != 0) begin
                ch = telegram_mem[telegram_rd_ptr];
                telegram_rd_ptr = telegram_rd_ptr + 1'b1;
                telegram_count = telegram_count - 1'b1;
                from_telegram = 1'b1;
            end else begin
                telegram_on = 1'b0;
            end
        end
        if (!from_telegram) begin
            if (ticker_len == 0) begin
                ticker_idx = '0;
                letter_word = SPACE_WORD;
                sym_pos = '0;
                return;
            end
            ch = ticker_mem[ticker_idx];
            idx_next = {1'b0, ticker_idx} + 1'b1;
            if (idx_next >= ticker_len || idx_next >= TICKER_DEPTH) begin
                ticker_idx = '0;
            end else begin
                ticker_idx = idx_next[TK_AW-1:0];
            end
        end
        letter_word = morse_word(ch);
        sym_pos = '0;
    endfunction

    function automatic void key_unit();
        t_symbol sym;
        if (tick_cnt != 0) begin
            tick_cnt = tick_cnt - 1'b1;
            return;
        end
        sym = t_symbol'(letter_word[{sym_pos, 1'b0} +: 2]);
        case (sym)
            SYM_GAP: begin
                led = 1'b0;
                tick_cnt = TICK_W'(unit_ticks);
            end
            SYM_DOT: begin
                led = 1'b1;
                tick_cnt = TICK_W'(unit_ticks);
            end
            SYM_DASH: begin
                led = 1'b1;
                tick_cnt = TICK_W'(unit_ticks) * TICK_W'(3);
            end
            default: begin
                led = 1'b0;
                tick_cnt = {1'b0, unit_ticks, 1'b0};
                fetch_letter();
                return;
            end
        endcase
        sym_pos = sym_pos + 1'b1;
    endfunction

    function automatic t_out_item apply_request(input t_in_item req);
        t_out_item        status;
        logic [TG_AW-1:0] wr_ptr;
        case (req.action)
            ACT_TICK: begin
                if (telegram_on || ticker_len != 0) begin
                    key_unit();
                end
            end
            ACT_WRITE: begin
                ticker_mem[req.slot] = req.char_code;
            end
            ACT_PUSH: begin
                telegram_on = 1'b1;
                if (telegram_count < TELEGRAM_DEPTH) begin
                    wr_ptr = telegram_rd_ptr + telegram_count[TG_AW-1:0];
                    telegram_mem[wr_ptr] = req.char_code;
                    telegram_count = telegram_count + 1'b1;
                end
            end
            default: begin
                fetch_letter();
            end
        endcase
        status.led_on          = led;
        status.telegram_active = telegram_on;
        status.keyer_running   = telegram_on || (ticker_len != 0);
        status.fifo_full       = (telegram_count >= TELEGRAM_DEPTH);
        return status;
    endfunction

    function automatic void compare_flag(input string name, input logic exp_v, input logic act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0b, got %0b", name, exp_v, act_v);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_status;
        if (!i_rst_n) begin
            unit_ticks      = UNIT_TICKS_RESET;
            ticker_len      = '0;
            letter_word     = SPACE_WORD;
            sym_pos         = '0;
            tick_cnt        = '0;
            ticker_idx      = '0;
            telegram_count  = '0;
            telegram_rd_ptr = '0;
            telegram_on     = 1'b0;
            led             = 1'b0;
            status_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    o_mismatches++;
                end else begin
                    exp_status = status_q.pop_front();
                    compare_flag("led_on", exp_status.led_on, i_out.led_on);
                    compare_flag("telegram_active", exp_status.telegram_active,
                                 i_out.telegram_active);
                    compare_flag("keyer_running", exp_status.keyer_running,
                                 i_out.keyer_running);
                    compare_flag("fifo_full", exp_status.fifo_full, i_out.fifo_full);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_UNIT_TICKS:    unit_ticks = i_cfg_data[UNIT_W-1:0];
                    CFG_TICKER_LENGTH: ticker_len = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                status_q.push_back(apply_request(i_in));
            end
        end
        o_pending = status_q.size();
    end

endmodule

// ===== test/tb_morse_code_led_keyer.sv =====
module tb_morse_code_led_keyer;
    timeunit 1ns;
    timeprecision 1ps;
    import mclk_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    t_in_item           i_in;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out;
    logic               i_out_stall;
    logic               i_cfg_we;
    t_cfg_index         i_cfg_index;
    logic [CFG_DW-1:0]  i_cfg_data;

    int mismatches;
    int pending_results;
    int cycle_count = 0;
    int no_gap_left = 0;

    morse_code_led_keyer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    morse_keyer_status_check status_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in         (i_in),
        .i_in_stall   (o_in_stall),
        .i_out_valid  (o_out_valid),
        .i_out        (o_out),
        .i_out_stall  (i_out_stall),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 1) == 0) begin
            return CHAR_W'($urandom_range(65, 90));
        end
        return CHAR_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        return SLOT_W'($urandom_range(0, 31));
    endfunction

    // The result side stalls in random bursts, with the odd long clear stretch.
    initial begin
        int n;
        i_out_stall = 1'b0;
        forever begin
            n = gap_len();
            if (n > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 5)) @(negedge i_clk);
        end
    end

    task automatic pause_sender(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_request(input t_action act, input logic [CHAR_W-1:0] ch,
                                input logic [SLOT_W-1:0] s);
        t_in_item req;
        req.action    = act;
        req.char_code = ch;
        req.slot      = s;
        if (no_gap_left > 0) begin
            no_gap_left--;
        end else begin
            pause_sender(gap_len());
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DW-1:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_ticks(input int n);
        repeat (n) send_request(ACT_TICK, pick_char(), pick_slot());
    endtask

    task automatic run_phase(input logic [UNIT_W-1:0] unit, input logic [LEN_W-1:0] len,
                             input int n_items, input int push_pct);
        int sent;
        int pick;
        int burst;
        write_reg(CFG_UNIT_TICKS, unit);
        write_reg(CFG_TICKER_LENGTH, CFG_DW'(len));
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 2) begin
                settle();
            end
            if (no_gap_left == 0 && $urandom_range(0, 99) < 4) begin
                no_gap_left = $urandom_range(20, 60);
            end
            pick = $urandom_range(0, 99);
            if (pick < push_pct) begin
                send_request(ACT_PUSH, pick_char(), pick_slot());
                sent++;
            end else if (pick < push_pct + 8) begin
                send_request(ACT_WRITE, pick_char(), pick_slot());
                sent++;
            end else if (pick < push_pct + 13) begin
                send_request(ACT_LOAD, pick_char(), pick_slot());
                sent++;
            end else if (pick < push_pct + 15) begin
                // A whole message at once, now and then enough to overflow the FIFO.
                burst = ($urandom_range(0, 5) == 0) ? 34 : $urandom_range(2, 6);
                repeat (burst) send_request(ACT_PUSH, pick_char(), pick_slot());
                sent += burst;
            end else begin
                send_request(ACT_TICK, pick_char(), pick_slot());
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_UNIT_TICKS;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idle keyer: a tick changes nothing and a load gives the space code.
        send_request(ACT_TICK, 7'd127, 5'd31);
        send_request(ACT_LOAD, 7'd0, 5'd0);
        send_request(ACT_PUSH, 7'd69, 5'd0);
        run_ticks(3);

        // Every ticker slot is written before the ticker is ever enabled.
        for (int i = 0; i < TICKER_DEPTH; i++) begin
            if (i == 0) begin
                send_request(ACT_WRITE, 7'd0, SLOT_W'(i));
            end else if (i == TICKER_DEPTH - 1) begin
                send_request(ACT_WRITE, 7'd127, SLOT_W'(i));
            end else begin
                send_request(ACT_WRITE, pick_char(), SLOT_W'(i));
            end
        end

        write_reg(CFG_UNIT_TICKS, 16'd0);
        send_request(ACT_PUSH, 7'd0, 5'd31);
        send_request(ACT_PUSH, 7'd127, 5'd0);
        send_request(ACT_PUSH, 7'd84, 5'd7);
        send_request(ACT_LOAD, 7'd1, 5'd1);
        run_ticks(120);
        send_request(ACT_LOAD, 7'd2, 5'd2);
        write_reg(CFG_TICKER_LENGTH, 16'd1);
        run_ticks(12);
        send_request(ACT_LOAD, 7'd5, 5'd3);
        send_request(ACT_LOAD, 7'd6, 5'd4);
        run_ticks(10);

        run_phase(16'd0, 6'd0, 200, 12);
        run_phase(16'd1, 6'd1, 200, 6);
        run_phase(16'd2, 6'd5, 200, 10);
        run_phase(16'd0, 6'd32, 250, 4);
        run_phase(16'd3, 6'd17, 200, 15);
        run_phase(16'd1, 6'd32, 200, 3);
        repeat (2) begin
            run_phase(UNIT_W'($urandom_range(0, 3)), LEN_W'($urandom_range(1, 31)), 200,
                      $urandom_range(2, 15));
        end
        // Longest unit last, since its reload keeps the countdown busy for ages.
        run_phase(16'hFFFF, 6'd32, 80, 10);

        settle();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
